>>> hw/rtl/olist_pkg.sv
package olist_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic       load;
        logic       append;
        logic       issue;
        logic       compare;
        logic       shift_wr;
        logic       dec_count;
        logic       finish;
        logic       fin_query;
        logic [1:0] fin_status;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic miss;
        logic rd_vld;
    } sts_t;

endpackage

>>> hw/rtl/olist_ctrl.sv
module olist_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          func,
    input  olist_pkg::sts_t     sts,
    output olist_pkg::cmd_t     cmd,
    output logic                busy
);
    import olist_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_QSUCC = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       is_remove_reg;
    logic       is_remove_next;

    always_comb
    begin
        cmd            = '0;
        cmd.fin_status = ST_OK;
        state_next     = state_reg;
        is_remove_next = is_remove_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        OP_APPEND:
                        begin
                            cmd.finish = 1'b1;
                            if (sts.full)
                            begin
                                cmd.fin_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                        end
                        OP_REMOVE, OP_QUERY:
                        begin
                            if (sts.empty)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.load       = 1'b1;
                                is_remove_next = (func == OP_REMOVE);
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.issue   = 1'b1;
                cmd.compare = 1'b1;
                if (sts.hit)
                begin
                    state_next = is_remove_reg ? S_SHIFT : S_QSUCC;
                end
                else if (sts.miss)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
            end
            S_QSUCC:
            begin
                cmd.finish    = 1'b1;
                cmd.fin_query = 1'b1;
                state_next    = S_IDLE;
            end
            S_SHIFT:
            begin
                cmd.issue    = 1'b1;
                cmd.shift_wr = 1'b1;
                if (!sts.rd_vld)
                begin
                    cmd.finish    = 1'b1;
                    cmd.dec_count = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_remove_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_remove_reg <= is_remove_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hw/rtl/olist_dp.sv
module olist_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  olist_pkg::cmd_t     cmd,
    input  logic signed [31:0]  value,
    output olist_pkg::sts_t     sts,
    output logic                done,
    output logic [1:0]          status,
    output logic                pred_valid,
    output logic signed [31:0]  pred_value,
    output logic                succ_valid,
    output logic signed [31:0]  succ_value
);
    import olist_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [31:0]   mem [MAX_ENTRIES];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] rd_idx_next;
    logic          rd_vld_reg;
    logic          prev_vld_reg;
    logic          prev_vld_next;
    logic          done_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic [31:0]   rd_data_reg;
    logic [31:0]   value_reg;
    logic [31:0]   prev_reg;
    logic [1:0]    status_reg;
    logic          pred_valid_reg;
    logic [31:0]   pred_value_reg;
    logic          succ_valid_reg;
    logic [31:0]   succ_value_reg;

    logic          rd_en;
    logic          hit;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          take_prev;
    logic          rep_pred;
    logic          rep_succ;

    always_comb
    begin
        rd_en     = cmd.issue && (rd_idx_reg < count_reg);
        hit       = rd_vld_reg && (rd_data_reg == value_reg);
        take_prev = cmd.compare && rd_vld_reg && !hit;
        mem_we    = cmd.append || (cmd.shift_wr && rd_vld_reg);
        wr_addr   = cmd.append ? count_reg[AW-1:0] : (cmp_idx_reg - AW'(1));
        wr_data   = cmd.append ? 32'(value) : rd_data_reg;
        rep_pred  = cmd.fin_query && prev_vld_reg;
        rep_succ  = cmd.fin_query && rd_vld_reg;

        sts.empty  = (count_reg == '0);
        sts.full   = (count_reg == CW'(MAX_ENTRIES));
        sts.hit    = hit;
        sts.miss   = !rd_vld_reg && (rd_idx_reg >= count_reg);
        sts.rd_vld = rd_vld_reg;

        if (cmd.load)
        begin
            rd_idx_next = '0;
        end
        else if (rd_en)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
        else
        begin
            rd_idx_next = rd_idx_reg;
        end

        if (cmd.load)
        begin
            prev_vld_next = 1'b0;
        end
        else if (take_prev)
        begin
            prev_vld_next = 1'b1;
        end
        else
        begin
            prev_vld_next = prev_vld_reg;
        end

        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            prev_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            rd_vld_reg   <= rd_en;
            prev_vld_reg <= prev_vld_next;
            done_reg     <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= 32'(value);
        end
        if (rd_en)
        begin
            cmp_idx_reg <= rd_idx_reg[AW-1:0];
        end
        if (take_prev)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            status_reg     <= cmd.fin_status;
            pred_valid_reg <= rep_pred;
            pred_value_reg <= rep_pred ? prev_reg : 32'd0;
            succ_valid_reg <= rep_succ;
            succ_value_reg <= rep_succ ? rd_data_reg : 32'd0;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign pred_valid = pred_valid_reg;
    assign pred_value = pred_value_reg;
    assign succ_valid = succ_valid_reg;
    assign succ_value = succ_value_reg;

endmodule

>>> hw/rtl/ordered_value_list.sv
// Ordered value list: an insertion-ordered store of signed 32-bit values.
// Command channel: a beat is taken at a rising edge with start high and
// busy low; func selects append, remove first match or query neighbours,
// and value carries the operand.
// Result channel: done pulses for one cycle with status and the neighbour
// fields; every command gives exactly one result beat. The receiver has
// no way to stall, so results must be taken the cycle they are shown.
// Flow: append, empty or full cases and unused codes finish in the
// accept cycle, with done in the next cycle and busy never raised, so
// these run at one beat per cycle. Remove and query scan the entry memory
// one entry per cycle through its registered read port. A query match then
// reports its neighbours, and a remove match moves later entries up one
// place per cycle through the same port; a miss ends after the last entry.
// Done shows in the first cycle with busy low.
// Reset empties the list at once; stored values need no clearing.
module ordered_value_list #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic signed [31:0]  value,
    output logic                done,
    output logic [1:0]          status,
    output logic                pred_valid,
    output logic signed [31:0]  pred_value,
    output logic                succ_valid,
    output logic signed [31:0]  succ_value
);
    import olist_pkg::*;

    cmd_t cmd;
    sts_t sts;

    olist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    olist_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .sts        (sts),
        .done       (done),
        .status     (status),
        .pred_valid (pred_valid),
        .pred_value (pred_value),
        .succ_valid (succ_valid),
        .succ_value (succ_value)
    );

endmodule

>>> hw/rtl/olist_chk.sv
module olist_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [1:0]          func,
    input logic signed [31:0]  value,
    input logic                done,
    input logic [1:0]          status,
    input logic                pred_valid,
    input logic signed [31:0]  pred_value,
    input logic                succ_valid,
    input logic signed [31:0]  succ_value
);
    import olist_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func != OP_REMOVE && func != OP_QUERY) |=> (done && !busy))
        else $error("append or unused code did not finish at once");

    a_no_nbr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (!pred_valid && !succ_valid))
        else $error("neighbour flagged on failed beat");

    a_zero_vals: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((pred_valid || pred_value == 0) && (succ_valid || succ_value == 0)))
        else $error("neighbour value not cleared");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a command");

endmodule

bind ordered_value_list olist_chk u_chk (.*);

>>> bench/tb_ordered_value_list.sv
`timescale 1ns / 1ps

module tb_ordered_value_list;

    import olist_pkg::*;

    localparam int          LIST_DEPTH  = 16;
    localparam int          RANDOM_OPS  = 1550;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic        pred_valid;
        logic [31:0] pred_value;
        logic        succ_valid;
        logic [31:0] succ_value;
    } olist_result_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [31:0]   operand;
        logic [4:0]    reps;
        logic          typed;
        olist_result_t want;
    } stim_row_t;

    localparam olist_result_t RES_OK        = '{ST_OK, 1'b0, 32'd0, 1'b0, 32'd0};
    localparam olist_result_t RES_NOT_FOUND = '{ST_NOT_FOUND, 1'b0, 32'd0, 1'b0, 32'd0};
    localparam olist_result_t RES_EMPTY     = '{ST_EMPTY, 1'b0, 32'd0, 1'b0, 32'd0};
    localparam olist_result_t RES_FULL      = '{ST_FULL, 1'b0, 32'd0, 1'b0, 32'd0};

    localparam int DIRECTED_ROWS = 26;

    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{OP_REMOVE, 32'd5,        5'd1,  1'b1, RES_EMPTY},
        '{OP_QUERY,  32'd5,        5'd1,  1'b1, RES_EMPTY},
        '{OP_UNUSED, 32'hFFFFFFFF, 5'd1,  1'b1, RES_OK},
        '{OP_APPEND, 32'h80000000, 5'd1,  1'b1, RES_OK},
        '{OP_QUERY,  32'h80000000, 5'd1,  1'b1, RES_OK},
        '{OP_REMOVE, 32'h80000000, 5'd1,  1'b1, RES_OK},
        '{OP_APPEND, 32'h80000000, 5'd1,  1'b1, RES_OK},
        '{OP_APPEND, 32'h7FFFFFFF, 5'd1,  1'b1, RES_OK},
        '{OP_APPEND, 32'h00000000, 5'd1,  1'b1, RES_OK},
        '{OP_APPEND, 32'hFFFFFFFF, 5'd1,  1'b1, RES_OK},
        '{OP_APPEND, 32'h7FFFFFFF, 5'd1,  1'b1, RES_OK},
        '{OP_QUERY,  32'h80000000, 5'd1,  1'b0, RES_OK},
        '{OP_QUERY,  32'hFFFFFFFF, 5'd1,  1'b0, RES_OK},
        '{OP_QUERY,  32'h7FFFFFFF, 5'd1,  1'b0, RES_OK},
        '{OP_QUERY,  32'd1234,     5'd1,  1'b1, RES_NOT_FOUND},
        '{OP_REMOVE, 32'd1234,     5'd1,  1'b1, RES_NOT_FOUND},
        '{OP_REMOVE, 32'h7FFFFFFF, 5'd1,  1'b0, RES_OK},
        '{OP_QUERY,  32'h7FFFFFFF, 5'd1,  1'b0, RES_OK},
        '{OP_REMOVE, 32'h80000000, 5'd1,  1'b0, RES_OK},
        '{OP_APPEND, 32'h55555555, 5'd13, 1'b1, RES_OK},
        '{OP_APPEND, 32'hAAAAAAAA, 5'd1,  1'b1, RES_FULL},
        '{OP_QUERY,  32'h55555555, 5'd1,  1'b0, RES_OK},
        '{OP_QUERY,  32'h7FFFFFFF, 5'd1,  1'b0, RES_OK},
        '{OP_REMOVE, 32'h55555555, 5'd1,  1'b0, RES_OK},
        '{OP_APPEND, 32'hAAAAAAAA, 5'd1,  1'b1, RES_OK},
        '{OP_QUERY,  32'hAAAAAAAA, 5'd1,  1'b0, RES_OK}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         func;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic               pred_valid;
    logic signed [31:0] pred_value;
    logic               succ_valid;
    logic signed [31:0] succ_value;

    logic [31:0]   shadow_list [$];
    olist_result_t expected_results [$];
    olist_result_t oldest_expected;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            idle_enabled = 1'b1;

    ordered_value_list #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .value      (value),
        .done       (done),
        .status     (status),
        .pred_valid (pred_valid),
        .pred_value (pred_value),
        .succ_valid (succ_valid),
        .succ_value (succ_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic olist_result_t predict_list_op(input logic [1:0] op,
                                                      input logic [31:0] operand);
        olist_result_t res;
        int            pos;
        res = '0;
        pos = -1;
        for (int k = 0; k < shadow_list.size(); k++)
        begin
            if (pos < 0 && shadow_list[k] == operand)
                pos = k;
        end
        case (op)
            OP_APPEND:
            begin
                if (shadow_list.size() >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                    shadow_list.push_back(operand);
            end
            OP_REMOVE:
            begin
                if (shadow_list.size() == 0)
                    res.status = ST_EMPTY;
                else if (pos < 0)
                    res.status = ST_NOT_FOUND;
                else
                    shadow_list.delete(pos);
            end
            OP_QUERY:
            begin
                if (shadow_list.size() == 0)
                    res.status = ST_EMPTY;
                else if (pos < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    if (pos > 0)
                    begin
                        res.pred_valid = 1'b1;
                        res.pred_value = shadow_list[pos-1];
                    end
                    if (pos + 1 < shadow_list.size())
                    begin
                        res.succ_valid = 1'b1;
                        res.succ_value = shadow_list[pos+1];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // hold the beat until busy is low at a rising edge, then log its result
    task automatic send_beat(input logic [1:0] op, input logic [31:0] operand,
                             input logic use_typed, input olist_result_t typed_want);
        olist_result_t predicted;
        if (idle_enabled && $urandom_range(99) < 7)
        begin
            start = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        start = 1'b1;
        func  = op;
        value = operand;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_list_op(op, operand);
        expected_results.push_back(use_typed ? typed_want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: status %0d", status);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (status !== oldest_expected.status
                    || pred_valid !== oldest_expected.pred_valid
                    || pred_value !== oldest_expected.pred_value
                    || succ_valid !== oldest_expected.succ_valid
                    || succ_value !== oldest_expected.succ_value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d %0b %h %0b %h, got %0d %0b %h %0b %h",
                                 oldest_expected.status, oldest_expected.pred_valid,
                                 oldest_expected.pred_value, oldest_expected.succ_valid,
                                 oldest_expected.succ_value, status, pred_valid,
                                 pred_value, succ_valid, succ_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned pool_pick;
        bit          growing;
        logic [1:0]  op;
        logic [31:0] operand;

        rst_n   = 1'b0;
        start   = 1'b0;
        func    = OP_APPEND;
        value   = '0;
        growing = 1'b1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            for (int n = 0; n < directed_rows[r].reps; n++)
                send_beat(directed_rows[r].op, directed_rows[r].operand,
                          directed_rows[r].typed, directed_rows[r].want);
        end
        drain_results();

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 64 == 0)
                growing = 1'($urandom_range(1, 0));
            idle_enabled = !(i >= 400 && i < 700);
            if (i == 1000)
                drain_results();

            pick = $urandom_range(99);
            if (pick < 3)
                op = OP_UNUSED;
            else if (pick < (growing ? 60 : 18))
                op = OP_APPEND;
            else if (pick < 78)
                op = OP_REMOVE;
            else
                op = OP_QUERY;

            // favour values already stored so removes and queries hit
            pool_pick = $urandom_range(99);
            if (pool_pick < 50 && shadow_list.size() > 0)
                operand = shadow_list[$urandom_range(shadow_list.size() - 1, 0)];
            else if (pool_pick < 75)
                operand = int'($urandom_range(8, 0)) - 4;
            else
                operand = $urandom();

            send_beat(op, operand, 1'b0, RES_OK);
        end

        drain_results();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
